FILE: src/spq_pkg.sv
// Shared types for the sorted priority queue.
package spq_pkg;

    // Command broadcast from the control logic to every cell of the chain.
    typedef struct packed {
        logic ins;   // insert the new entry at its sorted place
        logic rem;   // remove the head, every entry moves one cell towards it
    } t_cmd;

    // Operation codes carried in the input tuser field.
    localparam logic FUNC_ENQUEUE = 1'b0;
    localparam logic FUNC_DEQUEUE = 1'b1;

endpackage

FILE: src/spq_cell.sv
// One storage cell of the sorted chain: holds one entry and trades it with its neighbours.
module spq_cell #(
    parameter int PRIO_BITS = 16,
    parameter int DATA_BITS = 32,
    parameter bit HEAD      = 1'b0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  spq_pkg::t_cmd        i_cmd,
    input  logic [PRIO_BITS-1:0] i_new_prio,
    input  logic [DATA_BITS-1:0] i_new_data,
    input  logic                 i_left_valid,
    input  logic                 i_left_move,
    input  logic [PRIO_BITS-1:0] i_left_prio,
    input  logic [DATA_BITS-1:0] i_left_data,
    input  logic                 i_right_valid,
    input  logic [PRIO_BITS-1:0] i_right_prio,
    input  logic [DATA_BITS-1:0] i_right_data,
    output logic                 o_valid,
    output logic                 o_move,
    output logic [PRIO_BITS-1:0] o_prio,
    output logic [DATA_BITS-1:0] o_data
);

    logic                 r_valid, n_valid;
    logic [PRIO_BITS-1:0] r_prio, n_prio;
    logic [DATA_BITS-1:0] r_data, n_data;
    logic                 w_after;

    // The new entry belongs before this one. The head only yields to a strictly
    // lower priority; later cells yield to an equal one as well.
    assign w_after = HEAD ? (r_prio > i_new_prio) : (r_prio >= i_new_prio);
    assign o_move  = !r_valid || w_after;

    // Next contents: on insert, cells at and after the insertion point shift away
    // from the head, the first of them taking the new entry; on remove, each cell takes its right neighbour's entry.
    always_comb begin
        n_valid = r_valid;
        n_prio  = r_prio;
        n_data  = r_data;
        if (i_cmd.ins) begin
            n_valid = r_valid | i_left_valid;
            if (o_move) begin
                if (i_left_move) begin
                    n_prio = i_left_prio;
                    n_data = i_left_data;
                end else begin
                    n_prio = i_new_prio;
                    n_data = i_new_data;
                end
            end
        end else if (i_cmd.rem) begin
            n_valid = i_right_valid;
            n_prio  = i_right_prio;
            n_data  = i_right_data;
        end
    end

    // Occupancy bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Entry contents.
    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_prio  = r_prio;
    assign o_data  = r_data;

endmodule

FILE: src/sorted_priority_queue.sv
// Sorted priority queue built as a chain of compare-and-shift cells.
//
// The queue keeps up to DEPTH entries in a row of cells ordered by ascending
// priority, the head in the first cell. Every cell compares its own priority
// with the incoming one in parallel, so an enqueue or a dequeue updates the
// whole chain at once. The result is registered and appears on the master
// side in the cycle after its transfer is accepted, held in an output
// register. A new transfer is taken whenever that register is empty or its
// result leaves in the same cycle, so with the master side always ready one
// transfer is taken per cycle. While a result waits on the master side, the
// slave side stalls. An enqueue whose priority is below the head's becomes
// the head; otherwise it goes after the head, before the first later entry
// of equal or greater priority. An enqueue into a full queue is dropped and
// reported as overflow; a dequeue of an empty queue reports nothing found.
// Each result carries the occupancy after the operation.
module sorted_priority_queue #(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 16,
    parameter int DATA_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // priority_req, payload
    input  logic [((PRIO_BITS + DATA_BITS + 7) / 8) * 8 - 1:0] i_s_tdata,
    // func
    input  logic                i_s_tuser,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // found, out_priority, out_payload, overflow, occupancy
    output logic [((PRIO_BITS + DATA_BITS + $clog2(DEPTH + 1) + 9) / 8) * 8 - 1:0] o_m_tdata
);

    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int IN_RAW  = PRIO_BITS + DATA_BITS;
    localparam int IN_W    = ((IN_RAW + 7) / 8) * 8;
    localparam int OUT_RAW = 2 + PRIO_BITS + DATA_BITS + CNT_W;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    logic [PRIO_BITS-1:0] w_new_prio;
    logic [DATA_BITS-1:0] w_new_data;
    logic                 w_accept, w_enq, w_full, w_empty;
    spq_pkg::t_cmd        w_cmd;

    logic [DEPTH-1:0]     w_valid, w_move;
    logic [PRIO_BITS-1:0] w_prio [DEPTH];
    logic [DATA_BITS-1:0] w_data [DEPTH];

    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_out_valid;
    logic                 r_found, r_overflow;
    logic [PRIO_BITS-1:0] r_out_prio;
    logic [DATA_BITS-1:0] r_out_data;
    logic [CNT_W-1:0]     r_out_count;

    // Input unpacking and transfer control.
    assign w_new_prio = i_s_tdata[PRIO_BITS-1:0];
    assign w_new_data = i_s_tdata[IN_RAW-1:PRIO_BITS];
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_enq      = (i_s_tuser == spq_pkg::FUNC_ENQUEUE);
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_cmd.ins  = w_accept && w_enq && !w_full;
    assign w_cmd.rem  = w_accept && !w_enq && !w_empty;

    // Chain of cells.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                 w_lv, w_lm, w_rv;
        logic [PRIO_BITS-1:0] w_lp, w_rp;
        logic [DATA_BITS-1:0] w_ld, w_rd;

        if (g == 0) begin : g_head
            assign w_lv = 1'b1;
            assign w_lm = 1'b0;
            assign w_lp = '0;
            assign w_ld = '0;
        end else begin : g_body
            assign w_lv = w_valid[g-1];
            assign w_lm = w_move[g-1];
            assign w_lp = w_prio[g-1];
            assign w_ld = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_rv = 1'b0;
            assign w_rp = '0;
            assign w_rd = '0;
        end else begin : g_inner
            assign w_rv = w_valid[g+1];
            assign w_rp = w_prio[g+1];
            assign w_rd = w_data[g+1];
        end

        spq_cell #(
            .PRIO_BITS (PRIO_BITS),
            .DATA_BITS (DATA_BITS),
            .HEAD      (g == 0)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_new_prio    (w_new_prio),
            .i_new_data    (w_new_data),
            .i_left_valid  (w_lv),
            .i_left_move   (w_lm),
            .i_left_prio   (w_lp),
            .i_left_data   (w_ld),
            .i_right_valid (w_rv),
            .i_right_prio  (w_rp),
            .i_right_data  (w_rd),
            .o_valid       (w_valid[g]),
            .o_move        (w_move[g]),
            .o_prio        (w_prio[g]),
            .o_data        (w_data[g])
        );
    end

    // Entry count after this operation.
    always_comb begin
        n_count = r_count;
        if (w_cmd.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_cmd.rem) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register, loaded with each accepted transfer.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_found     <= w_cmd.rem;
            r_out_prio  <= w_cmd.rem ? w_prio[0] : '0;
            r_out_data  <= w_cmd.rem ? w_data[0] : '0;
            r_overflow  <= w_enq && w_full;
            r_out_count <= n_count;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'({r_out_count, r_overflow, r_out_data, r_out_prio, r_found});

    // Checks on the cell chain and the entry count.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_valid_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("cell valid bits disagree with entry count");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ins |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not add one entry");

    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[1] |-> w_prio[0] <= w_prio[1])
        else $error("head priority above its successor");

endmodule
